[src/tcw_pkg.sv]
// Shared types and constants for the text console character writer.
package tcw_pkg;

  // Screen geometry defaults
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Field widths
  localparam int CODE_W   = 8;
  localparam int ADDR_IN_W = 11;
  localparam int CURSOR_W = 11;
  localparam int CELL_W   = 16;
  localparam int STYLE_W  = 8;

  // Character codes
  localparam logic [CODE_W-1:0] SPACE_CODE = 8'd32;
  localparam logic [CODE_W-1:0] PRINT_LOW  = 8'd32;
  localparam logic [CODE_W-1:0] PRINT_HIGH = 8'd127;
  localparam logic [CODE_W-1:0] CODE_BS    = 8'd8;
  localparam logic [CODE_W-1:0] CODE_TAB   = 8'd9;
  localparam logic [CODE_W-1:0] CODE_LF    = 8'd10;
  localparam logic [CODE_W-1:0] CODE_FF    = 8'd12;
  localparam logic [CODE_W-1:0] CODE_CR    = 8'd13;

  localparam int TAB_STOP = 8;

  localparam logic [STYLE_W-1:0] STYLE_RESET = 8'h07;

  // Commands and status
  localparam logic CMD_PUT       = 1'b0;
  localparam logic CMD_READ      = 1'b1;
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [CODE_W-1:0]    char_code;
    logic [ADDR_IN_W-1:0] cell_addr;
  } in_item_t;

  typedef struct packed {
    logic                status;
    logic [CURSOR_W-1:0] cursor_pos;
    logic [CELL_W-1:0]   cell_data;
  } out_item_t;

endpackage

[src/tcw_if.sv]
// Handshake channel interfaces: put/read items, results and style writes.
interface tcw_in_if;
  logic               valid;
  logic               ready;
  tcw_pkg::in_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface tcw_out_if;
  logic               valid;
  logic               ready;
  tcw_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface tcw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::STYLE_W-1:0]   cell_style;
  modport source (output valid, output cell_style, input ready);
  modport sink   (input valid, input cell_style, output ready);
endinterface

[src/tcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

[src/text_console_char_writer.sv]
// Top level of the text console character writer: cursor control and screen store.
// A put item that only prints or moves the cursor leaves the sequencer idle, and the
// next item can follow at once while the result register is free. A read item passes
// through a read state for the registered read of the screen RAM. A form feed, or a
// put that runs the cursor off the end of the screen, sweeps the whole screen RAM one
// cell a cycle through its single write port, a scroll copying each row up one and
// blanking the last. After reset the RAM is cleared to blanks by the same sweep,
// during which no item is accepted; style writes are taken at any time. Each item
// yields one result, held in an output register.
module text_console_char_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_cfg_if.sink   cfg_i,
  tcw_in_if.sink    in_i,
  tcw_out_if.source out_o
);
  import tcw_pkg::*;

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int KEEP       = COLUMNS * (ROWS - 1);
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int COLX_W     = $clog2(COLUMNS + TAB_STOP);
  localparam int ROW_W      = $clog2(ROWS + 1);
  localparam int CMP_W      = ADDR_W + ADDR_IN_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [STYLE_W-1:0] style_q;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ADDR_W-1:0]  sw_ptr_q, sw_ptr_d;
  logic               sw_clear_q, sw_clear_d;
  logic               rst_clear_q, rst_clear_d;
  logic               wr_v_q, wr_v_d;
  logic [ADDR_W-1:0]  wr_addr_q;
  logic               wr_blank_q;
  logic               read_oor_q;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q, out_item_d;

  logic               in_acc;
  logic               out_free;
  logic [ADDR_W-1:0]  cur_lin;
  logic [COLX_W-1:0]  col_inc;
  logic [COLX_W-1:0]  ncol;
  logic [ROW_W-1:0]   nrow;
  logic [COL_W-1:0]   fcol;
  logic [ROW_W-1:0]   frow;
  logic [ADDR_W-1:0]  new_lin;
  logic               put_reject;
  logic               put_print;
  logic               put_clear;
  logic               scroll;
  logic               start_sweep;
  logic               sweep_last;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;
  logic [STYLE_W-1:0] blank_style;

  // Handshakes
  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && out_free;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

  // Linear cursor position
  assign cur_lin = ADDR_W'(row_q * COLUMNS) + ADDR_W'(col_q);
  assign col_inc = COLX_W'(col_q) + COLX_W'(1);

  // Next cursor for a put item, before end-of-screen handling
  always_comb begin
    ncol       = COLX_W'(col_q);
    nrow       = row_q;
    put_reject = 1'b0;
    put_print  = 1'b0;
    put_clear  = 1'b0;
    if (in_i.item.char_code >= PRINT_LOW && in_i.item.char_code <= PRINT_HIGH) begin
      put_print = 1'b1;
      ncol      = col_inc;
    end else begin
      case (in_i.item.char_code)
        CODE_BS: begin
          if (col_q != '0) begin
            ncol = COLX_W'(col_q) - COLX_W'(1);
          end
        end
        CODE_TAB: begin
          // Step one, then up to the last column of the tab stop
          if (col_inc == COLX_W'(COLUMNS)) begin
            ncol = col_inc;
          end else begin
            ncol = col_inc | COLX_W'(TAB_STOP - 1);
          end
        end
        CODE_LF: ncol = COLX_W'(COLUMNS);
        CODE_FF: put_clear = 1'b1;
        CODE_CR: ncol = '0;
        default: put_reject = 1'b1;
      endcase
    end
    // Wrap into the next row
    if (ncol >= COLX_W'(COLUMNS)) begin
      ncol = ncol - COLX_W'(COLUMNS);
      nrow = row_q + ROW_W'(1);
    end
  end

  assign scroll      = !put_reject && (nrow == ROW_W'(ROWS));
  assign fcol        = scroll ? '0 : COL_W'(ncol);
  assign frow        = scroll ? ROW_W'(ROWS - 1) : nrow;
  assign new_lin     = ADDR_W'(frow * COLUMNS) + ADDR_W'(fcol);
  assign start_sweep = in_acc && (in_i.item.cmd == CMD_PUT) && (scroll || put_clear);
  assign sweep_last  = (sw_ptr_q == ADDR_W'(CELL_COUNT - 1));

  // Control sequencer and sweep pointer
  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    sw_ptr_d    = sw_ptr_q;
    sw_clear_d  = sw_clear_q;
    rst_clear_d = rst_clear_q;
    wr_v_d      = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;
    out_item_d  = out_item_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_item_d.status     = STATUS_OK;
          out_item_d.cursor_pos = CURSOR_W'(cur_lin);
          out_item_d.cell_data  = '0;
          if (in_i.item.cmd == CMD_READ) begin
            state_d = S_READ;
          end else begin
            out_valid_d = 1'b1;
            if (put_reject) begin
              out_item_d.status = STATUS_REJECT;
            end else begin
              row_d                 = frow;
              col_d                 = fcol;
              out_item_d.cursor_pos = CURSOR_W'(new_lin);
            end
            if (start_sweep) begin
              state_d    = S_SWEEP;
              sw_ptr_d   = '0;
              sw_clear_d = put_clear;
            end
          end
        end
      end
      S_READ: begin
        out_valid_d          = 1'b1;
        out_item_d.cell_data = read_oor_q ? '0 : ram_rdata;
        state_d              = S_IDLE;
      end
      S_SWEEP: begin
        wr_v_d   = 1'b1;
        sw_ptr_d = sw_ptr_q + ADDR_W'(1);
        if (sweep_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        rst_clear_d = 1'b0;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      style_q     <= STYLE_RESET;
      row_q       <= '0;
      col_q       <= '0;
      sw_ptr_q    <= '0;
      sw_clear_q  <= 1'b1;
      rst_clear_q <= 1'b1;
      wr_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      sw_ptr_q    <= sw_ptr_d;
      sw_clear_q  <= sw_clear_d;
      rst_clear_q <= rst_clear_d;
      wr_v_q      <= wr_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        style_q <= cfg_i.cell_style;
      end
    end
  end

  // Payload registers: sweep write stage, read range flag, result
  always_ff @(posedge clk_i) begin
    wr_addr_q  <= sw_ptr_q;
    wr_blank_q <= sw_clear_q || (sw_ptr_q >= ADDR_W'(KEEP));
    read_oor_q <= CMP_W'(in_i.item.cell_addr) >= CMP_W'(CELL_COUNT);
    out_item_q <= out_item_d;
  end

  // RAM port selection: each sweep write lands in the cycle after its read
  assign blank_style = rst_clear_q ? STYLE_RESET : style_q;
  assign ram_raddr   = (state_q == S_SWEEP) ? ADDR_W'(32'(sw_ptr_q) + COLUMNS)
                                            : ADDR_W'(in_i.item.cell_addr);
  always_comb begin
    if (wr_v_q) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_q;
      ram_wdata = wr_blank_q ? {blank_style, SPACE_CODE} : ram_rdata;
    end else begin
      ram_we    = in_acc && (in_i.item.cmd == CMD_PUT) && put_print;
      ram_waddr = cur_lin;
      ram_wdata = {style_q, in_i.item.char_code};
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Checks
  a_cursor_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS))
    else $error("cursor out of screen");

  a_read_no_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> !ram_we)
    else $error("RAM write during read");

  a_drain_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |=> (state_q == S_IDLE) && !wr_v_q)
    else $error("sweep did not finish cleanly");

  a_sweep_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_sweep |=> out_valid_q && (state_q == S_SWEEP))
    else $error("sweep item lost its result");

  a_write_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_v_q |-> (32'(wr_addr_q) < CELL_COUNT))
    else $error("sweep write beyond store");

endmodule

[test/tb_text_console_char_writer.sv]
// Self-checking testbench for the text console character writer: prediction and scoreboard.
module tb_text_console_char_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int          COLUMNS     = COLUMNS_DEF;
  localparam int          ROWS        = ROWS_DEF;
  localparam int unsigned CELLS       = COLUMNS * ROWS;
  localparam int unsigned KEEP        = COLUMNS * (ROWS - 1);
  localparam int unsigned ADDR_TOP    = (1 << ADDR_IN_W) - 1;
  // a sweep of the screen RAM plus some slack
  localparam int unsigned SWEEP_PAUSE = CELLS + 64;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned PER_PHASE   = 160;
  localparam int unsigned CYCLE_LIMIT = 10_000_000;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_SPARSE, RX_BLOCKED} rx_mode_e;

  // Screen predictor and result scoreboard
  class screen_scoreboard;
    logic [CELL_W-1:0]  screen_mem [CELLS];
    int unsigned        cur_pos;
    logic [STYLE_W-1:0] style_q;
    out_item_t          result_q [$];
    int unsigned        errors, n_checked, n_put, n_refused, n_read, n_scroll, n_clear;

    function new();
      style_q = STYLE_RESET;
      cur_pos = 0;
      blank_from(0);
    endfunction

    function void set_style(logic [STYLE_W-1:0] s);
      style_q = s;
    endfunction

    function void blank_from(int unsigned first);
      for (int unsigned i = first; i < CELLS; i++) screen_mem[i] = {style_q, SPACE_CODE};
    endfunction

    // work out the result of one accepted item and queue it
    function void note_input(in_item_t it);
      out_item_t   res;
      int unsigned col;
      int unsigned c2;
      bit          moved;
      res        = '0;
      res.status = STATUS_OK;
      col        = cur_pos % COLUMNS;
      moved      = 1'b1;
      if (it.cmd == CMD_READ) begin
        n_read++;
        if (it.cell_addr < CELLS) res.cell_data = screen_mem[it.cell_addr];
      end else begin
        n_put++;
        if (it.char_code >= PRINT_LOW && it.char_code <= PRINT_HIGH) begin
          screen_mem[cur_pos] = {style_q, it.char_code};
          cur_pos++;
        end else begin
          case (it.char_code)
            CODE_BS: if (col > 0) cur_pos--;
            CODE_TAB: begin
              cur_pos++;
              c2 = cur_pos % COLUMNS;
              if (c2 > 0) cur_pos += (TAB_STOP - 1) - (c2 % TAB_STOP);
            end
            CODE_LF: cur_pos += COLUMNS - col;
            CODE_FF: begin
              blank_from(0);
              n_clear++;
            end
            CODE_CR: cur_pos -= col;
            default: begin
              res.status = STATUS_REJECT;
              moved      = 1'b0;
              n_refused++;
            end
          endcase
        end
        // ran off the end: scroll one row, cursor to start of last row
        if (moved && cur_pos >= CELLS) begin
          for (int unsigned i = 0; i < KEEP; i++) screen_mem[i] = screen_mem[i + COLUMNS];
          blank_from(KEEP);
          cur_pos = KEEP;
          n_scroll++;
        end
      end
      res.cursor_pos = cur_pos[CURSOR_W-1:0];
      result_q.push_back(res);
    endfunction

    // compare one result with the oldest outstanding one
    function void check_result(out_item_t got);
      out_item_t want;
      if (result_q.size() == 0) begin
        $error("result with no item outstanding: status %0d cursor_pos %0d cell_data 0x%04h",
               got.status, got.cursor_pos, got.cell_data);
        errors++;
        return;
      end
      want = result_q.pop_front();
      n_checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.cursor_pos !== want.cursor_pos) begin
        $error("cursor_pos: expected %0d, actual %0d", want.cursor_pos, got.cursor_pos);
        errors++;
      end
      if (got.cell_data !== want.cell_data) begin
        $error("cell_data: expected 0x%04h, actual 0x%04h", want.cell_data, got.cell_data);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  screen_scoreboard sb;
  int unsigned      burst_left;
  int unsigned      cycle_cnt = 0;
  logic [5:0]       stall_cnt = '0;
  rx_mode_e         stall_mode = RX_FREE;

  tcw_cfg_if cfg_if ();
  tcw_in_if  in_if ();
  tcw_out_if out_if ();

  text_console_char_writer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Result side stalls on a pattern picked anew each time the 6-bit stall counter wraps
  initial out_if.ready = 1'b0;
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1'b1;
    if (stall_cnt == '0) stall_mode <= rx_mode_e'($urandom_range(0, 3));
    case (stall_mode)
      RX_FREE:   out_if.ready <= 1'b1;
      RX_RANDOM: out_if.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_if.ready <= (stall_cnt[1:0] == 2'd0);
      default:   out_if.ready <= (stall_cnt[4:0] >= 5'd20);
    endcase
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result(out_if.item);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("run stopped by watchdog after %0d cycles", cycle_cnt);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic in_item_t mk_item(logic c, logic [CODE_W-1:0] k,
                                       logic [ADDR_IN_W-1:0] a);
    in_item_t it;
    it.cmd       = c;
    it.char_code = k;
    it.cell_addr = a;
    return it;
  endfunction

  // Drive one item; valid stays high inside a burst, drops for the gap after it
  task automatic send_item(input in_item_t it);
    in_if.valid <= 1'b1;
    in_if.item  <= it;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    sb.note_input(it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12);
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // Let every result come home and any sweep finish
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.result_q.size() != 0) @(posedge clk_i);
    repeat (SWEEP_PAUSE) @(posedge clk_i);
  endtask

  task automatic write_style(input logic [STYLE_W-1:0] s);
    cfg_if.valid      <= 1'b1;
    cfg_if.cell_style <= s;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    sb.set_style(s);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    in_item_t           directed_q [$];
    in_item_t           it;
    logic [STYLE_W-1:0] style_plan [PHASES];
    int unsigned        pick;
    int unsigned        span;

    sb                = new();
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.item        = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.cell_style = '0;
    burst_left        = $urandom_range(1, 12);
    style_plan        = '{8'h00, 8'hFF, 8'($urandom), STYLE_RESET, 8'($urandom)};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset contents, address extremes, every put code, refused codes
    directed_q.push_back(mk_item(CMD_READ, 8'h00, 11'd0));
    directed_q.push_back(mk_item(CMD_READ, 8'hFF, 11'(CELLS - 1)));
    directed_q.push_back(mk_item(CMD_READ, 8'h00, 11'(ADDR_TOP)));
    directed_q.push_back(mk_item(CMD_PUT, PRINT_LOW, 11'(ADDR_TOP)));
    directed_q.push_back(mk_item(CMD_PUT, PRINT_HIGH, 11'd0));
    directed_q.push_back(mk_item(CMD_PUT, 8'h41, 11'd0));
    directed_q.push_back(mk_item(CMD_PUT, 8'd128, 11'd0));
    directed_q.push_back(mk_item(CMD_PUT, 8'd31, 11'd0));
    directed_q.push_back(mk_item(CMD_PUT, 8'd0, 11'd0));
    directed_q.push_back(mk_item(CMD_PUT, 8'd255, 11'(ADDR_TOP)));
    directed_q.push_back(mk_item(CMD_PUT, 8'd11, 11'd0));
    directed_q.push_back(mk_item(CMD_PUT, CODE_BS, 11'd0));
    directed_q.push_back(mk_item(CMD_PUT, CODE_TAB, 11'd0));
    directed_q.push_back(mk_item(CMD_PUT, CODE_TAB, 11'd0));
    directed_q.push_back(mk_item(CMD_PUT, CODE_CR, 11'd0));
    directed_q.push_back(mk_item(CMD_PUT, CODE_BS, 11'd0));
    directed_q.push_back(mk_item(CMD_PUT, CODE_TAB, 11'd0));
    directed_q.push_back(mk_item(CMD_PUT, CODE_LF, 11'd0));
    directed_q.push_back(mk_item(CMD_READ, 8'h00, 11'd1));
    directed_q.push_back(mk_item(CMD_READ, 8'h00, 11'd2));
    directed_q.push_back(mk_item(CMD_PUT, CODE_FF, 11'd0));
    directed_q.push_back(mk_item(CMD_READ, 8'h00, 11'd2));
    directed_q.push_back(mk_item(CMD_READ, 8'h00, 11'd0));
    foreach (directed_q[i]) send_item(directed_q[i]);

    // Random phases, one style setting each
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_style(style_plan[ph]);
      repeat (PER_PHASE) begin
        pick         = $urandom_range(0, 99);
        it.cmd       = CMD_PUT;
        it.char_code = CODE_W'($urandom_range(0, 255));
        it.cell_addr = ADDR_IN_W'($urandom_range(0, ADDR_TOP));
        if (pick < 15) begin
          // reads: mostly just behind the cursor, some anywhere, a few off screen
          it.cmd = CMD_READ;
          span   = $urandom_range(0, 9);
          if (span == 0) begin
            it.cell_addr = ADDR_IN_W'($urandom_range(CELLS, ADDR_TOP));
          end else if (span < 4) begin
            it.cell_addr = ADDR_IN_W'($urandom_range(0, CELLS - 1));
          end else begin
            span         = $urandom_range(0, 2 * COLUMNS);
            it.cell_addr = (span <= sb.cur_pos) ? 11'(sb.cur_pos - span)
                                                : 11'($urandom_range(0, CELLS - 1));
          end
        end else if (pick < 60) begin
          it.char_code = CODE_W'($urandom_range(PRINT_LOW, PRINT_HIGH));
        end else if (pick < 68) begin
          it.char_code = CODE_LF;
        end else if (pick < 75) begin
          it.char_code = CODE_TAB;
        end else if (pick < 80) begin
          it.char_code = CODE_BS;
        end else if (pick < 85) begin
          it.char_code = CODE_CR;
        end else if (pick < 87) begin
          it.char_code = CODE_FF;
        end else begin
          do it.char_code = CODE_W'($urandom_range(0, 255));
          while ((it.char_code >= PRINT_LOW && it.char_code <= PRINT_HIGH) ||
                 (it.char_code inside {CODE_BS, CODE_TAB, CODE_LF, CODE_FF, CODE_CR}));
        end
        send_item(it);
      end
    end

    wait_idle();
    $display("Covered %0d puts (%0d refused), %0d reads, %0d scrolls, %0d clears, %0d styles",
             sb.n_put, sb.n_refused, sb.n_read, sb.n_scroll, sb.n_clear, PHASES + 1);
    $display("%0d results checked, %0d field mismatches", sb.n_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
src/tcw_pkg.sv
src/tcw_if.sv
src/tcw_ram.sv
src/text_console_char_writer.sv
test/tb_text_console_char_writer.sv
